// ===== rtl/mpic_pkg.sv =====
`default_nettype none
package mpic_pkg;
  localparam int MAX_CORES = 4;
  localparam int NUM_LINES = 256;
  localparam int WORDS_PER_CORE = 4;
  localparam int NUM_WORDS = MAX_CORES * WORDS_PER_CORE;
  localparam int LINE_W = $clog2(NUM_LINES);
  localparam int WIDX_W = $clog2(NUM_WORDS);
  localparam int CORE_W = 2;
  localparam int NCORE_W = 3;
  localparam int PRIO_W = 8;
  localparam int IN_DATA_W = 56;
  localparam int OUT_DATA_W = 56;

  localparam logic [3:0] REQ_RAISE = 4'd0;
  localparam logic [3:0] REQ_RD_PEND = 4'd1;
  localparam logic [3:0] REQ_WR_EN = 4'd2;
  localparam logic [3:0] REQ_RD_EN = 4'd3;
  localparam logic [3:0] REQ_WR_PRIO = 4'd4;
  localparam logic [3:0] REQ_RD_PRIO = 4'd5;
  localparam logic [3:0] REQ_EOI = 4'd6;
  localparam logic [3:0] REQ_TRIGGER = 4'd7;
  localparam logic [3:0] REQ_SELECT = 4'd8;
endpackage
`default_nettype wire

// ===== rtl/mpic_ram.sv =====
`default_nettype none
module mpic_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== rtl/multicore_priority_interrupt_controller.sv =====
// register access: result registered on acceptance; priority read goes via ST_PRIO
// select: scans every line through the one priority memory read port, one line
//   per cycle; result registered on acceptance if core invalid or blocked
// one request at a time; the next is taken the cycle after the result has been taken
// rst (synchronous): pending cleared, enables all ones, priorities zero, num_cores 1
`default_nettype none
module multicore_priority_interrupt_controller (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_data,   // num_cores
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // core[1:0] chunk[4:2] data_word[36:5] line_number[44:37] prio_value[52:45]
  // cpu_blocked[53]
  input  wire logic [55:0] s_tdata,
  input  wire logic [3:0]  s_tuser,    // req_type
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // read_data[31:0] irq_found[32] irq_line[40:33] irq_prio[48:41]
  output logic [55:0]      m_tdata
);
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_PRIO = 2'd1;
  localparam logic [1:0] ST_SCAN = 2'd2;

  logic [1:0] state;
  logic [mpic_pkg::NCORE_W-1:0] num_cores;
  logic [63:0] pending [mpic_pkg::NUM_WORDS];
  logic [63:0] enable [mpic_pkg::NUM_WORDS];
  logic [mpic_pkg::NUM_LINES-1:0] prio_valid;
  logic prio_valid_q;

  logic [mpic_pkg::CORE_W-1:0] core, scan_core;
  logic [2:0] ridx;
  logic [31:0] data;
  logic [7:0] line;
  logic [7:0] pval;
  logic blocked;
  logic accept;
  logic core_ok;
  logic [mpic_pkg::NCORE_W-1:0] lim;
  logic [mpic_pkg::WIDX_W-1:0] cw, lw, sw;
  logic [63:0] lbit;
  logic [31:0] rd_word;

  logic [mpic_pkg::LINE_W:0] idx;
  logic hit_d;
  logic [mpic_pkg::LINE_W-1:0] line_d;
  logic found;
  logic [mpic_pkg::LINE_W-1:0] bline;
  logic [mpic_pkg::PRIO_W-1:0] bprio;
  logic [mpic_pkg::PRIO_W-1:0] ram_q, prio_rd;
  logic ram_we;
  logic [mpic_pkg::LINE_W-1:0] ram_raddr;
  logic [63:0] scan_word;
  logic take;

  assign core = s_tdata[1:0];
  assign ridx = s_tdata[4:2];
  assign data = s_tdata[36:5];
  assign line = s_tdata[44:37];
  assign pval = s_tdata[52:45];
  assign blocked = s_tdata[53];

  assign s_tready = (state == ST_IDLE) && !m_tvalid;
  assign accept = s_tvalid && s_tready;
  assign lim = (num_cores > mpic_pkg::NCORE_W'(mpic_pkg::MAX_CORES)) ?
               mpic_pkg::NCORE_W'(mpic_pkg::MAX_CORES) : num_cores;
  assign core_ok = {1'b0, core} < lim;
  assign cw = {core, ridx[2:1]};
  assign lw = {core, line[7:6]};
  assign lbit = 64'd1 << line[5:0];
  assign sw = {scan_core, idx[7:6]};
  assign scan_word = pending[sw] & enable[sw];
  assign take = hit_d && (!found || prio_rd > bprio);

  assign ram_we = accept && (s_tuser == mpic_pkg::REQ_WR_PRIO);
  assign ram_raddr = (state == ST_SCAN) ? idx[mpic_pkg::LINE_W-1:0] : line;
  assign prio_rd = prio_valid_q ? ram_q : '0;

  always_comb begin
    rd_word = '0;
    case (s_tuser)
      mpic_pkg::REQ_RD_PEND: begin
        if (core_ok) rd_word = ridx[0] ? pending[cw][63:32] : pending[cw][31:0];
      end
      mpic_pkg::REQ_RD_EN: begin
        if (core_ok) rd_word = ridx[0] ? enable[cw][63:32] : enable[cw][31:0];
      end
      default: begin
        rd_word = '0;
      end
    endcase
  end

  mpic_ram #(.WIDTH(mpic_pkg::PRIO_W), .DEPTH(mpic_pkg::NUM_LINES)) u_prio (
    .clk   (clk),
    .we    (ram_we),
    .waddr (line),
    .wdata (pval),
    .raddr (ram_raddr),
    .rdata (ram_q)
  );

  always_ff @(posedge clk) begin
    prio_valid_q <= prio_valid[ram_raddr];
    if (rst) begin
      state <= ST_IDLE;
      num_cores <= mpic_pkg::NCORE_W'(1);
      m_tvalid <= 1'b0;
      prio_valid <= '0;
      for (int i = 0; i < mpic_pkg::NUM_WORDS; i++) begin
        pending[i] <= '0;
        enable[i] <= '1;
      end
    end else begin
      if (cfg_we) begin
        num_cores <= cfg_data;
      end
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            case (s_tuser)
              mpic_pkg::REQ_RAISE: begin
                if (core_ok) begin
                  if (ridx[0]) pending[cw][63:32] <= pending[cw][63:32] | data;
                  else pending[cw][31:0] <= pending[cw][31:0] | data;
                end
              end
              mpic_pkg::REQ_WR_EN: begin
                if (core_ok) begin
                  if (ridx[0]) enable[cw][63:32] <= data;
                  else enable[cw][31:0] <= data;
                end
              end
              mpic_pkg::REQ_WR_PRIO: begin
                prio_valid[line] <= 1'b1;
              end
              mpic_pkg::REQ_EOI: begin
                if (core_ok) pending[lw] <= pending[lw] & ~lbit;
              end
              mpic_pkg::REQ_TRIGGER: begin
                if (core_ok) pending[lw] <= pending[lw] | lbit;
              end
              default: begin
              end
            endcase
            if (s_tuser == mpic_pkg::REQ_RD_PRIO) begin
              state <= ST_PRIO;
            end else if ((s_tuser == mpic_pkg::REQ_SELECT) && core_ok && !blocked) begin
              scan_core <= core;
              idx <= '0;
              hit_d <= 1'b0;
              found <= 1'b0;
              bline <= '0;
              bprio <= '0;
              state <= ST_SCAN;
            end else begin
              m_tdata <= {24'd0, rd_word};
              m_tvalid <= 1'b1;
            end
          end
        end
        ST_PRIO: begin
          m_tdata <= {48'd0, prio_rd};
          m_tvalid <= 1'b1;
          state <= ST_IDLE;
        end
        ST_SCAN: begin
          if (take) begin
            found <= 1'b1;
            bline <= line_d;
            bprio <= prio_rd;
          end
          if (!idx[mpic_pkg::LINE_W]) begin
            hit_d <= scan_word[idx[5:0]];
            line_d <= idx[mpic_pkg::LINE_W-1:0];
            idx <= idx + 1'b1;
          end else begin
            m_tdata <= {7'd0, take ? prio_rd : bprio, take ? line_d : bline,
                        take | found, 32'd0};
            m_tvalid <= 1'b1;
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== rtl/mpic_checker.sv =====
`default_nettype none
module mpic_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [55:0] m_tdata
);
  // result held until taken
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result dropped while stalled");

  // one request at a time
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request taken while busy");

  a_outwait: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !s_tready)
    else $error("request taken while result waits");

  // no interrupt means zero line and priority
  a_nofind: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[32] |-> m_tdata[48:33] == 16'd0)
    else $error("line or priority without interrupt");
endmodule

bind multicore_priority_interrupt_controller mpic_checker u_mpic_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
`default_nettype wire

// ===== test/multicore_priority_interrupt_controller_tb.sv =====
`timescale 1ns / 1ps
module multicore_priority_interrupt_controller_tb;

  typedef struct packed {
    logic [7:0] prio;
    logic [7:0] line;
    logic found;
    logic [31:0] rdata;
  } irq_result_t;

  class irq_scoreboard;
    logic [63:0] pend[mpic_pkg::NUM_WORDS];
    logic [63:0] en[mpic_pkg::NUM_WORDS];
    logic [7:0] prio_tab[mpic_pkg::NUM_LINES];
    logic [2:0] ncores;
    irq_result_t pending_q[$];
    int errors;
    int checked;

    function void clear();
      foreach (pend[i]) begin
        pend[i] = '0;
        en[i] = '1;
      end
      foreach (prio_tab[i]) prio_tab[i] = '0;
      ncores = 3'd1;
    endfunction

    function void note_request(logic [3:0] req, logic [1:0] core, logic [2:0] ridx,
                               logic [31:0] data, logic [7:0] line, logic [7:0] pval,
                               logic blocked);
      irq_result_t r;
      int lim, cw, lw, sh, l;
      bit cok;
      logic [63:0] d;
      r = '0;
      lim = (ncores > mpic_pkg::MAX_CORES) ? mpic_pkg::MAX_CORES : ncores;
      cok = core < lim;
      cw = core * mpic_pkg::WORDS_PER_CORE + ridx / 2;
      sh = ridx[0] ? 32 : 0;
      lw = core * mpic_pkg::WORDS_PER_CORE + line / 64;
      case (req)
        mpic_pkg::REQ_RAISE: if (cok) pend[cw] |= 64'(data) << sh;
        mpic_pkg::REQ_RD_PEND: if (cok) r.rdata = 32'(pend[cw] >> sh);
        mpic_pkg::REQ_WR_EN:
          if (cok) en[cw] = (en[cw] & ~(64'hFFFF_FFFF << sh)) | (64'(data) << sh);
        mpic_pkg::REQ_RD_EN: if (cok) r.rdata = 32'(en[cw] >> sh);
        mpic_pkg::REQ_WR_PRIO: prio_tab[line] = pval;
        mpic_pkg::REQ_RD_PRIO: r.rdata = 32'(prio_tab[line]);
        mpic_pkg::REQ_EOI: if (cok) pend[lw][line[5:0]] = 1'b0;
        mpic_pkg::REQ_TRIGGER: if (cok) pend[lw][line[5:0]] = 1'b1;
        mpic_pkg::REQ_SELECT: if (cok && !blocked) begin
          for (int w = 0; w < mpic_pkg::WORDS_PER_CORE; w++) begin
            d = pend[core * mpic_pkg::WORDS_PER_CORE + w] &
                en[core * mpic_pkg::WORDS_PER_CORE + w];
            for (int b = 0; b < 64; b++) begin
              l = w * 64 + b;
              if (d[b] && (!r.found || prio_tab[l] > r.prio)) begin
                r.found = 1'b1;
                r.line = 8'(l);
                r.prio = prio_tab[l];
              end
            end
          end
        end
        default: ;
      endcase
      pending_q.push_back(r);
    endfunction

    task report(string what, longint exp, longint got);
      errors++;
      $display("mismatch %s: expected %0h got %0h (result %0d)", what, exp, got, checked);
    endtask

    task check_result(irq_result_t got);
      irq_result_t exp;
      checked++;
      if (pending_q.size() == 0) begin
        report("unexpected result", 0, got.rdata);
        return;
      end
      exp = pending_q.pop_front();
      if (got.rdata !== exp.rdata) report("read_data", exp.rdata, got.rdata);
      if (got.found !== exp.found) report("irq_found", exp.found, got.found);
      if (got.line !== exp.line) report("irq_line", exp.line, got.line);
      if (got.prio !== exp.prio) report("irq_prio", exp.prio, got.prio);
    endtask
  endclass

  logic clk = 0, rst = 1;
  logic cfg_we = 0;
  logic [2:0] cfg_data = 0;
  logic s_tvalid = 0, s_tready;
  logic [55:0] s_tdata = 0;
  logic [3:0] s_tuser = 0;
  logic m_tvalid, m_tready = 0;
  logic [55:0] m_tdata;
  irq_scoreboard sb = new();
  int idle_cycles = 0;
  int selects = 0;
  bit hold_off = 0;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  multicore_priority_interrupt_controller dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready)
      sb.note_request(s_tuser, s_tdata[1:0], s_tdata[4:2], s_tdata[36:5], s_tdata[44:37],
                      s_tdata[52:45], s_tdata[53]);
    if (!rst && m_tvalid && m_tready) sb.check_result(irq_result_t'(m_tdata[48:0]));
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic int gap_len();
    if ($urandom_range(0, 2) == 0) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(20, 300);
    return $urandom_range(1, 4);
  endfunction

  // result side: random stalls
  always @(negedge clk) begin
    if (hold_off) m_tready <= 1'b0;
    else m_tready <= ($urandom_range(0, 3) != 0);
  end

  task automatic send_request(logic [3:0] req, logic [1:0] core, logic [2:0] ridx,
                              logic [31:0] data, logic [7:0] line, logic [7:0] pval,
                              logic blocked, bit gaps = 1);
    int g;
    g = gaps ? gap_len() : 0;
    if (g > 0) begin
      s_tvalid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= req;
    s_tdata <= {2'b0, blocked, pval, line, data, ridx, core};
    if (req == mpic_pkg::REQ_SELECT) selects++;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.pending_q.size() != 0) @(negedge clk);
    repeat (300) @(negedge clk);
  endtask

  task automatic set_cores(logic [2:0] n);
    drain();
    cfg_we <= 1'b1;
    cfg_data <= n;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.ncores = n;
  endtask

  task automatic random_request();
    int k;
    logic [3:0] req;
    logic [31:0] data;
    k = $urandom_range(0, 20);
    if (k > 8) req = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(9, 15)) :
                     mpic_pkg::REQ_SELECT;
    else req = 4'(k);
    data = $urandom();
    if ($urandom_range(0, 1)) data = data & $urandom() & $urandom();
    send_request(req, 2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)), data,
                 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                 $urandom_range(0, 5) == 0);
  endtask

  initial begin
    sb.clear();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 0;
    // directed: extremes, every request kind, invalid core, blocked select, ties
    send_request(mpic_pkg::REQ_SELECT, 0, 0, 0, 0, 0, 0);
    send_request(mpic_pkg::REQ_TRIGGER, 0, 0, 0, 8'd255, 0, 0);
    send_request(mpic_pkg::REQ_TRIGGER, 0, 0, 0, 8'd3, 0, 0);
    send_request(mpic_pkg::REQ_SELECT, 0, 0, 0, 0, 0, 0);
    send_request(mpic_pkg::REQ_WR_PRIO, 0, 0, 0, 8'd255, 8'd255, 0);
    send_request(mpic_pkg::REQ_RD_PRIO, 3, 0, 0, 8'd255, 0, 0);
    send_request(mpic_pkg::REQ_SELECT, 0, 0, 0, 0, 0, 0);
    send_request(mpic_pkg::REQ_SELECT, 0, 0, 0, 0, 0, 1);
    send_request(mpic_pkg::REQ_RAISE, 0, 7, 32'hFFFF_FFFF, 0, 0, 0);
    send_request(mpic_pkg::REQ_RD_PEND, 0, 7, 0, 0, 0, 0);
    send_request(mpic_pkg::REQ_WR_EN, 0, 7, 32'h0000_0000, 0, 0, 0);
    send_request(mpic_pkg::REQ_RD_EN, 0, 7, 0, 0, 0, 0);
    send_request(mpic_pkg::REQ_RD_EN, 0, 0, 0, 0, 0, 0);
    send_request(mpic_pkg::REQ_EOI, 0, 0, 0, 8'd255, 0, 0);
    send_request(mpic_pkg::REQ_SELECT, 0, 0, 0, 0, 0, 0);
    send_request(mpic_pkg::REQ_RAISE, 1, 0, 32'hFFFF_FFFF, 0, 0, 0);
    send_request(mpic_pkg::REQ_RD_PEND, 1, 0, 0, 0, 0, 0);
    send_request(mpic_pkg::REQ_SELECT, 1, 0, 0, 0, 0, 0);
    send_request(4'd15, 0, 0, 32'hFFFF_FFFF, 8'hFF, 8'hFF, 1);
    set_cores(3'd0);
    send_request(mpic_pkg::REQ_TRIGGER, 0, 0, 0, 8'd1, 0, 0);
    send_request(mpic_pkg::REQ_RD_PEND, 0, 0, 0, 0, 0, 0);
    send_request(mpic_pkg::REQ_SELECT, 0, 0, 0, 0, 0, 0);
    set_cores(3'd7);
    send_request(mpic_pkg::REQ_RAISE, 3, 3, 32'h8000_0001, 0, 0, 0);
    send_request(mpic_pkg::REQ_SELECT, 3, 0, 0, 0, 0, 0);

    // long receiver hold-off while requests keep coming
    fork
      begin
        hold_off = 1;
        repeat (400) @(negedge clk);
        hold_off = 0;
      end
      repeat (8) send_request(mpic_pkg::REQ_RD_EN, 2'($urandom_range(0, 3)),
                              3'($urandom_range(0, 7)), 0, 0, 0, 0, 0);
    join

    for (int phase = 0; phase < 6; phase++) begin
      set_cores(phase == 0 ? 3'd1 : phase == 1 ? 3'd4 : phase == 2 ? 3'd2 :
                phase == 3 ? 3'd3 : phase == 4 ? 3'd0 : 3'd5);
      for (int i = 0; i < 100; i++) random_request();
    end

    drain();
    $display("covered %0d results, %0d select requests, several core counts incl. 0 and 7",
             sb.checked, selects);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule

// ===== multicore_priority_interrupt_controller.f =====
rtl/mpic_pkg.sv
rtl/mpic_ram.sv
rtl/multicore_priority_interrupt_controller.sv
rtl/mpic_checker.sv
test/multicore_priority_interrupt_controller_tb.sv
